### rtl/gqc_pkg.sv
// ----------------------------------------------------------------------------
// gqc_pkg
// Shared widths, constants and item types of the glyph quad clip unit.
// ----------------------------------------------------------------------------
package gqc_pkg;

  localparam int EDGE_W   = 48;  // fixed-point quad edge
  localparam int PIX_W    = 32;  // pixel coordinate
  localparam int SRC_W    = 16;  // atlas position and size
  localparam int TEX_FRAC = 16;  // texture coordinate fraction bits
  localparam int TEX_W    = 33;  // texture coordinate
  localparam int QUO_W    = 32;  // quotient bits, one per divider cell
  localparam int PROD_W   = PIX_W + SRC_W;
  localparam int SIZE_MAX = 65535;

  // Config register indexes
  localparam logic [1:0] REG_CLIP_LEFT   = 2'd0;
  localparam logic [1:0] REG_CLIP_TOP    = 2'd1;
  localparam logic [1:0] REG_CLIP_RIGHT  = 2'd2;
  localparam logic [1:0] REG_CLIP_BOTTOM = 2'd3;

  // Running state of one restoring division lane
  typedef struct packed {
    logic [PIX_W-1:0] rem;
    logic [PIX_W-1:0] div;
    logic [PIX_W-1:0] num;
    logic [QUO_W-1:0] quo;
  } div_lane_t;

  // Per-item control and payload that rides alongside the dividers
  typedef struct packed {
    logic                    valid;
    logic                    bad;
    logic                    vis;
    logic signed [PIX_W-1:0] cl;
    logic signed [PIX_W-1:0] ct;
    logic [SRC_W-1:0]        cw;
    logic [SRC_W-1:0]        ch;
    logic [SRC_W-1:0]        sx;
    logic [SRC_W-1:0]        sy;
  } item_tag_t;

  // Front end result: tag plus divider operands
  typedef struct packed {
    item_tag_t        tag;
    logic [PIX_W-1:0] rw;
    logic [PIX_W-1:0] rh;
    logic [PIX_W-1:0] ofs_l;
    logic [PIX_W-1:0] ofs_r;
    logic [PIX_W-1:0] ofs_t;
    logic [PIX_W-1:0] ofs_b;
    logic [SRC_W-1:0] sw;
    logic [SRC_W-1:0] sh;
  } front_out_t;

endpackage

### rtl/glyph_quad_clip_texcoord_top.sv
// ----------------------------------------------------------------------------
// glyph_quad_clip_texcoord_top
// Glyph quad scissor clip with exact texture coordinate interpolation.
// ----------------------------------------------------------------------------
//  Channel   Signals                             Handshake
//  --------  ----------------------------------  ------------------------------
//  command   start, busy, quad_*, src_*          item taken when start & !busy
//  result    done, status .. v_end               item valid for one cycle
//  config    cfg_we, cfg_index, cfg_data         write on cfg_we, no wait
//
//  An item is taken every cycle. Between command and result lie two front-end
//  stages, one multiply stage, the four divider chains side by side, 32 cells
//  each (one quotient bit per cell), and the output register. busy stays low:
//  the pipeline never holds the sender off.
//  Reset: rst clears the item valid bits and loads the scissor reset values.
//  The receiver cannot stall; results leave on done whether taken or not.
// ----------------------------------------------------------------------------
module glyph_quad_clip_texcoord_top #(
  parameter int FRAC_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [gqc_pkg::EDGE_W-1:0] quad_left,
  input  logic signed [gqc_pkg::EDGE_W-1:0] quad_top,
  input  logic signed [gqc_pkg::EDGE_W-1:0] quad_right,
  input  logic signed [gqc_pkg::EDGE_W-1:0] quad_bottom,
  input  logic [gqc_pkg::SRC_W-1:0]         src_x,
  input  logic [gqc_pkg::SRC_W-1:0]         src_y,
  input  logic [gqc_pkg::SRC_W-1:0]         src_width,
  input  logic [gqc_pkg::SRC_W-1:0]         src_height,
  input  logic                              cfg_we,
  input  logic [1:0]                        cfg_index,
  input  logic [gqc_pkg::PIX_W-1:0]         cfg_data,
  output logic                              done,
  output logic                              status,
  output logic                              visible,
  output logic signed [gqc_pkg::PIX_W-1:0]  pix_x,
  output logic signed [gqc_pkg::PIX_W-1:0]  pix_y,
  output logic [gqc_pkg::SRC_W-1:0]         tex_x,
  output logic [gqc_pkg::SRC_W-1:0]         tex_y,
  output logic [gqc_pkg::SRC_W-1:0]         pix_width,
  output logic [gqc_pkg::SRC_W-1:0]         pix_height,
  output logic [gqc_pkg::TEX_W-1:0]         u_start,
  output logic [gqc_pkg::TEX_W-1:0]         v_start,
  output logic [gqc_pkg::TEX_W-1:0]         u_end,
  output logic [gqc_pkg::TEX_W-1:0]         v_end
);
  import gqc_pkg::*;

  localparam int LANES = 4;

  // Scissor registers
  logic signed [PIX_W-1:0] clip_left, clip_top, clip_right, clip_bottom;

  always_ff @(posedge clk) begin
    if (rst) begin
      clip_left   <= PIX_W'(0);
      clip_top    <= PIX_W'(0);
      clip_right  <= PIX_W'(320);
      clip_bottom <= PIX_W'(240);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CLIP_LEFT:   clip_left   <= cfg_data;
        REG_CLIP_TOP:    clip_top    <= cfg_data;
        REG_CLIP_RIGHT:  clip_right  <= cfg_data;
        REG_CLIP_BOTTOM: clip_bottom <= cfg_data;
        default:         clip_left   <= clip_left;
      endcase
    end
  end

  assign busy = 1'b0;

  // Round, clip and classify
  front_out_t front;

  gqc_front #(
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (start),
    .quad_left   (quad_left),
    .quad_top    (quad_top),
    .quad_right  (quad_right),
    .quad_bottom (quad_bottom),
    .src_x       (src_x),
    .src_y       (src_y),
    .src_width   (src_width),
    .src_height  (src_height),
    .clip_left   (clip_left),
    .clip_top    (clip_top),
    .clip_right  (clip_right),
    .clip_bottom (clip_bottom),
    .front_out   (front)
  );

  // Multiply offset by source size; the product shifted by the texture
  // fraction is the dividend. Its top word seeds the remainder, which is
  // below the divisor because the offset never exceeds the full pixel size.
  logic [PROD_W-1:0] prod [LANES];
  logic [PIX_W-1:0]  divisor [LANES];
  div_lane_t         lane [LANES][QUO_W+1];
  item_tag_t         tag_pipe [QUO_W+1];

  always_comb begin
    prod[0] = PROD_W'(front.ofs_l) * PROD_W'(front.sw);
    prod[1] = PROD_W'(front.ofs_r) * PROD_W'(front.sw);
    prod[2] = PROD_W'(front.ofs_t) * PROD_W'(front.sh);
    prod[3] = PROD_W'(front.ofs_b) * PROD_W'(front.sh);
    divisor[0] = front.rw;
    divisor[1] = front.rw;
    divisor[2] = front.rh;
    divisor[3] = front.rh;
  end

  for (genvar i = 0; i < LANES; i++) begin : g_seed
    always_ff @(posedge clk) begin
      lane[i][0].rem <= prod[i][PROD_W-1:TEX_FRAC];
      lane[i][0].num <= {prod[i][TEX_FRAC-1:0], {(PIX_W-TEX_FRAC){1'b0}}};
      lane[i][0].div <= divisor[i];
      lane[i][0].quo <= '0;
    end
  end

  // Tag travels in step with the divider cells; reset clears valid only
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= QUO_W; k++) begin
        tag_pipe[k].valid <= 1'b0;
      end
    end else begin
      tag_pipe[0] <= front.tag;
      for (int k = 1; k <= QUO_W; k++) begin
        tag_pipe[k] <= tag_pipe[k-1];
      end
    end
  end

  // Divider chains: one quotient bit per cell, one cell per cycle
  for (genvar i = 0; i < LANES; i++) begin : g_lane
    for (genvar k = 0; k < QUO_W; k++) begin : g_cell
      gqc_div_cell u_cell (
        .clk      (clk),
        .lane_in  (lane[i][k]),
        .lane_out (lane[i][k+1])
      );
    end
  end

  // Add the source origin, check texture overflow, zero hidden results
  item_tag_t        t_end;
  logic [TEX_W-1:0] ul, ur, vt, vb;
  logic             tex_bad, st_next, vis_next;

  always_comb begin
    t_end = tag_pipe[QUO_W];
    ul = {1'b0, t_end.sx, {TEX_FRAC{1'b0}}} + TEX_W'(lane[0][QUO_W].quo);
    ur = {1'b0, t_end.sx, {TEX_FRAC{1'b0}}} + TEX_W'(lane[1][QUO_W].quo);
    vt = {1'b0, t_end.sy, {TEX_FRAC{1'b0}}} + TEX_W'(lane[2][QUO_W].quo);
    vb = {1'b0, t_end.sy, {TEX_FRAC{1'b0}}} + TEX_W'(lane[3][QUO_W].quo);
    tex_bad  = ul[TEX_W-1] | vt[TEX_W-1];
    st_next  = t_end.bad | (t_end.vis & tex_bad);
    vis_next = t_end.vis & ~tex_bad;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= t_end.valid;
    end
  end

  always_ff @(posedge clk) begin
    status  <= st_next;
    visible <= vis_next;
    if (vis_next) begin
      pix_x      <= t_end.cl;
      pix_y      <= t_end.ct;
      tex_x      <= ul[TEX_W-2:TEX_FRAC];
      tex_y      <= vt[TEX_W-2:TEX_FRAC];
      pix_width  <= t_end.cw;
      pix_height <= t_end.ch;
      u_start    <= ul;
      v_start    <= vt;
      u_end      <= ur;
      v_end      <= vb;
    end else begin
      pix_x      <= '0;
      pix_y      <= '0;
      tex_x      <= '0;
      tex_y      <= '0;
      pix_width  <= '0;
      pix_height <= '0;
      u_start    <= '0;
      v_start    <= '0;
      u_end      <= '0;
      v_end      <= '0;
    end
  end

endmodule

### rtl/gqc_div_cell.sv
// ----------------------------------------------------------------------------
// gqc_div_cell
// One restoring division step: shift in a numerator bit, compare, subtract.
// ----------------------------------------------------------------------------
module gqc_div_cell (
  input  logic              clk,
  input  gqc_pkg::div_lane_t lane_in,
  output gqc_pkg::div_lane_t lane_out
);
  import gqc_pkg::*;

  logic [PIX_W:0]   trial;
  logic             ge;
  div_lane_t        lane_next;

  always_comb begin
    trial = {lane_in.rem, lane_in.num[PIX_W-1]};
    ge    = trial >= {1'b0, lane_in.div};
    lane_next.div = lane_in.div;
    lane_next.num = {lane_in.num[PIX_W-2:0], 1'b0};
    lane_next.quo = {lane_in.quo[QUO_W-2:0], ge};
    if (ge) begin
      lane_next.rem = PIX_W'(trial - {1'b0, lane_in.div});
    end else begin
      lane_next.rem = trial[PIX_W-1:0];
    end
  end

  // payload only, no reset
  always_ff @(posedge clk) begin
    lane_out <= lane_next;
  end

endmodule

### rtl/gqc_front.sv
// ----------------------------------------------------------------------------
// gqc_front
// Round edges to pixels, clip against the scissor, classify the item.
// ----------------------------------------------------------------------------
module gqc_front #(
  parameter int FRAC_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  input  logic signed [gqc_pkg::EDGE_W-1:0]  quad_left,
  input  logic signed [gqc_pkg::EDGE_W-1:0]  quad_top,
  input  logic signed [gqc_pkg::EDGE_W-1:0]  quad_right,
  input  logic signed [gqc_pkg::EDGE_W-1:0]  quad_bottom,
  input  logic [gqc_pkg::SRC_W-1:0]          src_x,
  input  logic [gqc_pkg::SRC_W-1:0]          src_y,
  input  logic [gqc_pkg::SRC_W-1:0]          src_width,
  input  logic [gqc_pkg::SRC_W-1:0]          src_height,
  input  logic signed [gqc_pkg::PIX_W-1:0]   clip_left,
  input  logic signed [gqc_pkg::PIX_W-1:0]   clip_top,
  input  logic signed [gqc_pkg::PIX_W-1:0]   clip_right,
  input  logic signed [gqc_pkg::PIX_W-1:0]   clip_bottom,
  output gqc_pkg::front_out_t                front_out
);
  import gqc_pkg::*;

  localparam int WX = EDGE_W + 1;
  localparam logic signed [WX-1:0] ROUND = WX'((64'd1 << FRAC_BITS) - 64'd1);

  logic signed [WX-1:0] fl_w, ft_w, fr_w, fb_w;
  logic                 range_bad;

  // stage 1 registers
  logic                    s1_valid;
  logic                    s1_bad;
  logic signed [PIX_W-1:0] s1_fl, s1_ft, s1_fr, s1_fb;
  logic [SRC_W-1:0]        s1_sx, s1_sy, s1_sw, s1_sh;

  function automatic logic fits32(input logic signed [WX-1:0] v);
    fits32 = (&v[WX-1:PIX_W-1]) | ~(|v[WX-1:PIX_W-1]);
  endfunction

  always_comb begin
    fl_w = $signed({quad_left[EDGE_W-1], quad_left}) >>> FRAC_BITS;
    ft_w = $signed({quad_top[EDGE_W-1], quad_top}) >>> FRAC_BITS;
    fr_w = ($signed({quad_right[EDGE_W-1], quad_right}) + ROUND) >>> FRAC_BITS;
    fb_w = ($signed({quad_bottom[EDGE_W-1], quad_bottom}) + ROUND) >>> FRAC_BITS;
    range_bad = ~(fits32(fl_w) & fits32(ft_w) & fits32(fr_w) & fits32(fb_w));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_bad <= range_bad;
    s1_fl  <= fl_w[PIX_W-1:0];
    s1_ft  <= ft_w[PIX_W-1:0];
    s1_fr  <= fr_w[PIX_W-1:0];
    s1_fb  <= fb_w[PIX_W-1:0];
    s1_sx  <= src_x;
    s1_sy  <= src_y;
    s1_sw  <= src_width;
    s1_sh  <= src_height;
  end

  // stage 2: sizes and scissor
  logic signed [PIX_W:0]   rw, rh, cw, ch, ol, orr, ot, ob;
  logic signed [PIX_W-1:0] cl, ct, cr, cb;
  logic                    size_bad, empty, big;
  front_out_t              front_next;

  always_comb begin
    rw = {s1_fr[PIX_W-1], s1_fr} - {s1_fl[PIX_W-1], s1_fl};
    rh = {s1_fb[PIX_W-1], s1_fb} - {s1_ft[PIX_W-1], s1_ft};
    size_bad = rw[PIX_W] | (rw == '0) | rh[PIX_W] | (rh == '0);
    cl = (s1_fl > clip_left)   ? s1_fl : clip_left;
    ct = (s1_ft > clip_top)    ? s1_ft : clip_top;
    cr = (s1_fr < clip_right)  ? s1_fr : clip_right;
    cb = (s1_fb < clip_bottom) ? s1_fb : clip_bottom;
    empty = (cl >= cr) | (ct >= cb);
    cw  = {cr[PIX_W-1], cr} - {cl[PIX_W-1], cl};
    ch  = {cb[PIX_W-1], cb} - {ct[PIX_W-1], ct};
    big = (|cw[PIX_W:SRC_W]) | (|ch[PIX_W:SRC_W]);
    ol  = {cl[PIX_W-1], cl} - {s1_fl[PIX_W-1], s1_fl};
    orr = {cr[PIX_W-1], cr} - {s1_fl[PIX_W-1], s1_fl};
    ot  = {ct[PIX_W-1], ct} - {s1_ft[PIX_W-1], s1_ft};
    ob  = {cb[PIX_W-1], cb} - {s1_ft[PIX_W-1], s1_ft};

    front_next.tag.valid = s1_valid;
    front_next.tag.bad   = s1_bad | size_bad | (~empty & big);
    front_next.tag.vis   = ~s1_bad & ~size_bad & ~empty & ~big;
    front_next.tag.cl    = cl;
    front_next.tag.ct    = ct;
    front_next.tag.cw    = cw[SRC_W-1:0];
    front_next.tag.ch    = ch[SRC_W-1:0];
    front_next.tag.sx    = s1_sx;
    front_next.tag.sy    = s1_sy;
    front_next.rw    = rw[PIX_W-1:0];
    front_next.rh    = rh[PIX_W-1:0];
    front_next.ofs_l = ol[PIX_W-1:0];
    front_next.ofs_r = orr[PIX_W-1:0];
    front_next.ofs_t = ot[PIX_W-1:0];
    front_next.ofs_b = ob[PIX_W-1:0];
    front_next.sw    = s1_sw;
    front_next.sh    = s1_sh;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front_out.tag.valid <= 1'b0;
    end else begin
      front_out.tag.valid <= front_next.tag.valid;
    end
  end

  always_ff @(posedge clk) begin
    front_out.tag.bad <= front_next.tag.bad;
    front_out.tag.vis <= front_next.tag.vis;
    front_out.tag.cl  <= front_next.tag.cl;
    front_out.tag.ct  <= front_next.tag.ct;
    front_out.tag.cw  <= front_next.tag.cw;
    front_out.tag.ch  <= front_next.tag.ch;
    front_out.tag.sx  <= front_next.tag.sx;
    front_out.tag.sy  <= front_next.tag.sy;
    front_out.rw      <= front_next.rw;
    front_out.rh      <= front_next.rh;
    front_out.ofs_l   <= front_next.ofs_l;
    front_out.ofs_r   <= front_next.ofs_r;
    front_out.ofs_t   <= front_next.ofs_t;
    front_out.ofs_b   <= front_next.ofs_b;
    front_out.sw      <= front_next.sw;
    front_out.sh      <= front_next.sh;
  end

endmodule

### verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for glyph_quad_clip_texcoord_top. It sends glyph quads
// as commands and keeps an in-order queue of predicted clip and texture
// coordinate results. Each result strobe is compared field by field with the
// oldest prediction. Scissor settings change between phases, and only once
// the pipeline has drained.
// ----------------------------------------------------------------------------
module testbench;
  import gqc_pkg::*;

  // Pipeline depth of the block, plus some margin
  localparam int LATENCY      = 36;
  localparam int DRAIN_CYCLES = LATENCY + 8;
  localparam int WATCHDOG_MAX = 4000;

  typedef struct packed {
    bit                      status;
    bit                      vis;
    logic signed [PIX_W-1:0] px;
    logic signed [PIX_W-1:0] py;
    logic [SRC_W-1:0]        tx;
    logic [SRC_W-1:0]        ty;
    logic [SRC_W-1:0]        pw;
    logic [SRC_W-1:0]        ph;
    logic [TEX_W-1:0]        us;
    logic [TEX_W-1:0]        vs;
    logic [TEX_W-1:0]        ue;
    logic [TEX_W-1:0]        ve;
  } clip_result_t;

  // --------------------------------------------------------------------------
  // Clip predictor and in-order store of expected quads
  // --------------------------------------------------------------------------
  class clip_scoreboard;
    longint       scissor_l, scissor_t, scissor_r, scissor_b;
    clip_result_t pending_quads[$];
    int           mismatches;
    int           n_checked, n_visible, n_flagged;

    function new();
      reset_scissor();
      mismatches = 0;
      n_checked  = 0;
      n_visible  = 0;
      n_flagged  = 0;
    endfunction

    function void reset_scissor();
      scissor_l = 0;
      scissor_t = 0;
      scissor_r = 320;
      scissor_b = 240;
    endfunction

    function void write_scissor(logic [1:0] idx, logic [PIX_W-1:0] val);
      longint v;
      v = longint'(signed'(val));
      case (idx)
        REG_CLIP_LEFT:   scissor_l = v;
        REG_CLIP_TOP:    scissor_t = v;
        REG_CLIP_RIGHT:  scissor_r = v;
        REG_CLIP_BOTTOM: scissor_b = v;
        default: ;
      endcase
    endfunction

    // Interpolate one texture coordinate: base*2^16 + ofs*size*2^16 / span
    function bit [63:0] tex_coord(logic [SRC_W-1:0] base, logic [SRC_W-1:0] size,
                                  longint ofs, longint span);
      bit [63:0] b, s, o, d;
      b = {48'b0, base} << TEX_FRAC;
      s = {48'b0, size} << TEX_FRAC;
      o = ofs;
      d = span;
      return b + (o * s) / d;
    endfunction

    // Note an accepted quad and queue its predicted result
    function void note_quad(logic signed [EDGE_W-1:0] ql, logic signed [EDGE_W-1:0] qt,
                            logic signed [EDGE_W-1:0] qr, logic signed [EDGE_W-1:0] qb,
                            logic [SRC_W-1:0] sx, logic [SRC_W-1:0] sy,
                            logic [SRC_W-1:0] sw, logic [SRC_W-1:0] sh);
      clip_result_t r;
      longint fl, ft, fr, fb, rw, rh, cl, ct, cr, cb;
      bit [63:0] ul, ur, vt, vb;
      r = '{default: '0};
      // Round left and top down, right and bottom up
      fl = longint'(ql) >>> 16;
      ft = longint'(qt) >>> 16;
      fr = -((-longint'(qr)) >>> 16);
      fb = -((-longint'(qb)) >>> 16);
      if (fl < -64'sd2147483648 || fl > 64'sd2147483647 ||
          ft < -64'sd2147483648 || ft > 64'sd2147483647 ||
          fr < -64'sd2147483648 || fr > 64'sd2147483647 ||
          fb < -64'sd2147483648 || fb > 64'sd2147483647) begin
        r.status = 1'b1;
      end else begin
        rw = fr - fl;
        rh = fb - ft;
        cl = (fl > scissor_l) ? fl : scissor_l;
        ct = (ft > scissor_t) ? ft : scissor_t;
        cr = (fr < scissor_r) ? fr : scissor_r;
        cb = (fb < scissor_b) ? fb : scissor_b;
        if (rw <= 0 || rh <= 0) begin
          r.status = 1'b1;
        end else if (cl >= cr || ct >= cb) begin
          // empty intersection: all zero, status ok
        end else if (cr - cl > SIZE_MAX || cb - ct > SIZE_MAX) begin
          r.status = 1'b1;
        end else begin
          ul = tex_coord(sx, sw, cl - fl, rw);
          ur = tex_coord(sx, sw, cr - fl, rw);
          vt = tex_coord(sy, sh, ct - ft, rh);
          vb = tex_coord(sy, sh, cb - ft, rh);
          if ((ul >> TEX_FRAC) > SIZE_MAX || (vt >> TEX_FRAC) > SIZE_MAX) begin
            r.status = 1'b1;
          end else begin
            r.vis = 1'b1;
            r.px  = cl[PIX_W-1:0];
            r.py  = ct[PIX_W-1:0];
            r.tx  = ul[TEX_FRAC +: SRC_W];
            r.ty  = vt[TEX_FRAC +: SRC_W];
            r.pw  = 16'(cr - cl);
            r.ph  = 16'(cb - ct);
            r.us  = ul[TEX_W-1:0];
            r.vs  = vt[TEX_W-1:0];
            r.ue  = ur[TEX_W-1:0];
            r.ve  = vb[TEX_W-1:0];
          end
        end
      end
      pending_quads.push_back(r);
    endfunction

    // Compare one result against the oldest prediction
    function void check_result(clip_result_t got);
      clip_result_t exp_r;
      if (pending_quads.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result with no quad outstanding", $realtime);
        return;
      end
      exp_r = pending_quads.pop_front();
      n_checked++;
      if (exp_r.vis) n_visible++;
      if (exp_r.status) n_flagged++;
      if (got !== exp_r) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: mismatch", $realtime);
          $display("  exp st=%0d vis=%0d px=%0d py=%0d tx=%0d ty=%0d w=%0d h=%0d",
                   exp_r.status, exp_r.vis, exp_r.px, exp_r.py, exp_r.tx, exp_r.ty,
                   exp_r.pw, exp_r.ph);
          $display("  got st=%0d vis=%0d px=%0d py=%0d tx=%0d ty=%0d w=%0d h=%0d",
                   got.status, got.vis, got.px, got.py, got.tx, got.ty, got.pw, got.ph);
          $display("  exp u=%h..%h v=%h..%h  got u=%h..%h v=%h..%h",
                   exp_r.us, exp_r.ue, exp_r.vs, exp_r.ve,
                   got.us, got.ue, got.vs, got.ve);
        end
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT signals
  // --------------------------------------------------------------------------
  logic                     clk;
  logic                     rst;
  logic                     start;
  logic                     busy;
  logic signed [EDGE_W-1:0] quad_left, quad_top, quad_right, quad_bottom;
  logic [SRC_W-1:0]         src_x, src_y, src_width, src_height;
  logic                     cfg_we;
  logic [1:0]               cfg_index;
  logic [PIX_W-1:0]         cfg_data;
  logic                     done, status, visible;
  logic signed [PIX_W-1:0]  pix_x, pix_y;
  logic [SRC_W-1:0]         tex_x, tex_y, pix_width, pix_height;
  logic [TEX_W-1:0]         u_start, v_start, u_end, v_end;

  glyph_quad_clip_texcoord_top u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .quad_left(quad_left), .quad_top(quad_top),
    .quad_right(quad_right), .quad_bottom(quad_bottom),
    .src_x(src_x), .src_y(src_y), .src_width(src_width), .src_height(src_height),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .done(done), .status(status), .visible(visible),
    .pix_x(pix_x), .pix_y(pix_y), .tex_x(tex_x), .tex_y(tex_y),
    .pix_width(pix_width), .pix_height(pix_height),
    .u_start(u_start), .v_start(v_start), .u_end(u_end), .v_end(v_end)
  );

  clip_scoreboard quad_board = new();
  int             idle_cycles;   // cycles with neither an item taken nor a result
  int             n_sent;
  int             n_cfg_writes;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Monitor: all sampling happens at the rising edge, before the NBA region,
  // so both the driven inputs and the registered outputs are pre-edge values.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    clip_result_t got;
    if (!rst) begin
      if (cfg_we) quad_board.write_scissor(cfg_index, cfg_data);
      if (start && !busy)
        quad_board.note_quad(quad_left, quad_top, quad_right, quad_bottom,
                             src_x, src_y, src_width, src_height);
      if (done) begin
        got.status = status;  got.vis = visible;
        got.px = pix_x;       got.py = pix_y;
        got.tx = tex_x;       got.ty = tex_y;
        got.pw = pix_width;   got.ph = pix_height;
        got.us = u_start;     got.vs = v_start;
        got.ue = u_end;       got.ve = v_end;
        quad_board.check_result(got);
      end
      // Watchdog: any handshake resets the count
      if ((start && !busy) || done) idle_cycles <= 0;
      else                          idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_MAX) begin
        $display("timeout: no item accepted for %0d cycles", WATCHDOG_MAX);
        $display("** glyph_quad_clip_texcoord_top: FAILED **");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------

  // Send one quad; idle first at the given chance per hundred, then hold
  // start until the block takes the item.
  task automatic send_quad(logic signed [EDGE_W-1:0] l, logic signed [EDGE_W-1:0] t,
                           logic signed [EDGE_W-1:0] r, logic signed [EDGE_W-1:0] b,
                           logic [SRC_W-1:0] sx, logic [SRC_W-1:0] sy,
                           logic [SRC_W-1:0] sw, logic [SRC_W-1:0] sh,
                           int idle_pct);
    while ($urandom_range(99, 0) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start       <= 1'b1;
    quad_left   <= l;
    quad_top    <= t;
    quad_right  <= r;
    quad_bottom <= b;
    src_x       <= sx;
    src_y       <= sy;
    src_width   <= sw;
    src_height  <= sh;
    do @(posedge clk); while (busy);
    n_sent++;
  endtask

  // Lower start, then wait for every expected result and let the pipe empty
  task automatic drain_pipe();
    start <= 1'b0;
    @(posedge clk);
    while (quad_board.pending_quads.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Load all four scissor edges; only called with the pipe drained
  task automatic load_scissor(logic [PIX_W-1:0] l, logic [PIX_W-1:0] t,
                              logic [PIX_W-1:0] r, logic [PIX_W-1:0] b);
    logic [PIX_W-1:0] vals[4];
    vals = '{l, t, r, b};
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= 2'(i);
      cfg_data  <= vals[i];
      @(posedge clk);
      n_cfg_writes++;
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Pixel count plus random fraction, as a 48-bit fixed-point edge
  function automatic logic signed [EDGE_W-1:0] fx_edge(longint pix);
    return EDGE_W'((pix <<< 16) + longint'($urandom_range(65535, 0)));
  endfunction

  // One random quad; most land near the scissor so they clip in varied ways
  task automatic send_random_quad(int idle_pct);
    logic signed [EDGE_W-1:0] l, t, r, b;
    logic [SRC_W-1:0] sx, sy, sw, sh;
    longint cx, cy, w, h;
    int mode;
    mode = $urandom_range(19, 0);
    sx = SRC_W'($urandom);  sy = SRC_W'($urandom);
    sw = SRC_W'($urandom);  sh = SRC_W'($urandom);
    if ($urandom_range(3, 0) == 0) begin
      // keep texture origin low so the integer part stays in range
      sx = SRC_W'($urandom_range(2000, 0));
      sy = SRC_W'($urandom_range(2000, 0));
    end
    if ($urandom_range(31, 0) == 0) sw = '0;   // zero source size
    if ($urandom_range(31, 0) == 0) sh = '0;
    cx = longint'($urandom_range(600, 0)) - 150;
    cy = longint'($urandom_range(500, 0)) - 130;
    w  = $urandom_range(120, 1);
    h  = $urandom_range(120, 1);
    case (mode)
      0: begin
        // fully random bits on every edge
        l = EDGE_W'({$urandom, $urandom});  t = EDGE_W'({$urandom, $urandom});
        r = EDGE_W'({$urandom, $urandom});  b = EDGE_W'({$urandom, $urandom});
      end
      1: begin
        // wide quads to hit the clipped size limit
        w = $urandom_range(140000, 60000);
        h = $urandom_range(140000, 60000);
        l = fx_edge(cx - w / 2);  r = fx_edge(cx + w / 2);
        t = fx_edge(cy - h / 2);  b = fx_edge(cy + h / 2);
      end
      2: begin
        // edges near the 32-bit pixel boundary
        l = fx_edge(64'sd2147483647 - w);
        r = fx_edge(64'sd2147483647 + $urandom_range(1, 0) - 1);
        t = fx_edge(-64'sd2147483648 + $urandom_range(1, 0));
        b = fx_edge(-64'sd2147483648 + h);
      end
      3: begin
        // degenerate or inverted
        l = fx_edge(cx);  r = fx_edge(cx - $urandom_range(2, 0));
        t = fx_edge(cy);  b = fx_edge(cy + h);
      end
      default: begin
        l = fx_edge(cx);      t = fx_edge(cy);
        r = fx_edge(cx + w);  b = fx_edge(cy + h);
        if ($urandom_range(3, 0) == 0) begin
          // whole-pixel left and right edges
          l[15:0] = '0;  r[15:0] = '0;
        end
      end
    endcase
    send_quad(l, t, r, b, sx, sy, sw, sh, idle_pct);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  localparam logic signed [EDGE_W-1:0] EDGE_MAX = {1'b0, {(EDGE_W-1){1'b1}}};
  localparam logic signed [EDGE_W-1:0] EDGE_MIN = {1'b1, {(EDGE_W-1){1'b0}}};

  initial begin
    int idle_pct[4];
    idle_pct     = '{0, 48, 16, 0};
    idle_cycles  = 0;
    n_sent       = 0;
    n_cfg_writes = 0;
    rst         = 1'b1;
    start       = 1'b0;
    quad_left   = '0;  quad_top    = '0;
    quad_right  = '0;  quad_bottom = '0;
    src_x       = '0;  src_y       = '0;
    src_width   = '0;  src_height  = '0;
    cfg_we      = 1'b0;
    cfg_index   = REG_CLIP_LEFT;
    cfg_data    = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed quads against the reset scissor (0,0)-(320,240)
    send_quad(fx_edge(10), fx_edge(20), fx_edge(50), fx_edge(60), 5, 7, 40, 40, 0);
    send_quad(48'sh0_0000, 48'sh0_0000, 48'sh20_0000, 48'sh10_0000, 0, 0, 16, 16, 0);
    // extremes of every edge: right and bottom round out of 32-bit pixel range
    send_quad(EDGE_MIN, EDGE_MIN, EDGE_MAX, EDGE_MAX, 16'hFFFF, 16'hFFFF,
              16'hFFFF, 16'hFFFF, 0);
    send_quad(EDGE_MAX, EDGE_MAX, EDGE_MIN, EDGE_MIN, 0, 0, 1, 1, 0);
    // zero width, then negative height
    send_quad(fx_edge(30), fx_edge(30), 48'sh1E_0000, fx_edge(40), 1, 1, 8, 8, 0);
    send_quad(fx_edge(30), fx_edge(30), fx_edge(40), fx_edge(20), 1, 1, 8, 8, 0);
    // clipped on left and top: texture starts partway in
    send_quad(fx_edge(-25), fx_edge(-7), fx_edge(25), fx_edge(33), 100, 200, 50, 40, 0);
    // clipped on right and bottom
    send_quad(fx_edge(300), fx_edge(230), fx_edge(340), fx_edge(250), 9, 9, 13, 17, 0);
    // no overlap with the scissor
    send_quad(fx_edge(400), fx_edge(10), fx_edge(420), fx_edge(20), 1, 2, 3, 4, 0);
    // texture origin at the top with a clipped left edge: integer part overflows
    send_quad(fx_edge(-10), fx_edge(5), fx_edge(10), fx_edge(15), 16'hFFFF, 16'hFFFF,
              16'hFFFF, 16'hFFFF, 0);
    // zero source size
    send_quad(fx_edge(-5), fx_edge(-5), fx_edge(5), fx_edge(5), 77, 88, 0, 0, 0);
    // right edge one fraction step below pixel 32768 rounds up to it
    send_quad({16'hFFFF, 16'h8000, 16'h0000}, fx_edge(0),
              {16'h0000, 16'h7FFF, 16'hFFFF}, fx_edge(3), 0, 0, 2, 2, 0);
    send_quad({16'h0000, 16'h7FFF, 16'hFFFF} - 48'sh1, fx_edge(0),
              {16'h0000, 16'h7FFF, 16'hFFFF}, fx_edge(3), 0, 0, 2, 2, 0);
    // hold off until all expected results are in
    drain_pipe();

    // Huge scissor, then a clipped size beyond 16 bits, one at the limit, and a bottom edge past 32 bits
    load_scissor(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_quad(fx_edge(0), fx_edge(0), fx_edge(70000), fx_edge(10), 0, 0, 5, 5, 0);
    send_quad(fx_edge(0), fx_edge(0), fx_edge(65535), fx_edge(65535), 0, 0,
              16'hFFFF, 16'hFFFF, 0);
    send_quad(fx_edge(-2147483648), fx_edge(2147483600), fx_edge(-2147483600),
              fx_edge(2147483647), 3, 3, 9, 9, 0);
    drain_pipe();

    // Random phases, each under its own scissor and sender idling
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: load_scissor(32'd0, 32'd0, 32'd320, 32'd240);
        1: load_scissor(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        2: load_scissor(-32'sd50, -32'sd20, 32'd70, 32'd60);
        default: load_scissor(32'd200, 32'd150, 32'd100, 32'd50);   // inverted
      endcase
      for (int i = 0; i < 235; i++) send_random_quad(idle_pct[ph % 4]);
      drain_pipe();
    end

    $display("Sent %0d quads (%0d checked, %0d visible, %0d flagged), %0d scissor writes.",
             n_sent, quad_board.n_checked, quad_board.n_visible, quad_board.n_flagged,
             n_cfg_writes);
    $display("Covered reset, full-range, offset and inverted scissors; %0d mismatches.",
             quad_board.mismatches);
    if (quad_board.mismatches == 0 && quad_board.pending_quads.size() == 0) begin
      $display("** glyph_quad_clip_texcoord_top: PASSED **");
    end else begin
      $display("** glyph_quad_clip_texcoord_top: FAILED **");
    end
    $finish;
  end

endmodule
